[design/bcm_pkg.sv]
// bcm_pkg: shared constants, field widths, status and register codes for the
// block cache map. No dependencies; used by every other design file.
`default_nettype none

package bcm_pkg;

   // default sizes handed to the top level parameters
   localparam int SLOTS_DEF      = 256;
   localparam int MAX_BLOCKS_DEF = 4096;

   // field widths fixed by the interface
   localparam int ROW_W      = 12;
   localparam int COL_W      = 12;
   localparam int GEOM_W     = 13;
   localparam int STATUS_W   = 2;
   localparam int SLOT_OUT_W = 8;
   localparam int EVB_W      = 12;
   localparam int CSR_ADDR_W = 8;

   // block index datapath widths
   localparam int PROD_W = ROW_W + GEOM_W;
   localparam int SUM_W  = PROD_W + 1;

   typedef logic [STATUS_W-1:0]   status_type;
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;

   // response status codes
   localparam status_type ST_HIT   = 2'd0;
   localparam status_type ST_MISS  = 2'd1;
   localparam status_type ST_FLUSH = 2'd2;
   localparam status_type ST_RANGE = 2'd3;

   // configuration register indexes
   localparam csr_addr_type REG_BLOCKS_ACROSS = 8'd0;
   localparam csr_addr_type REG_BLOCKS_DOWN   = 8'd1;

endpackage

`default_nettype wire

[design/bcm_if.sv]
// bcm_if: valid/ready channel interfaces for requests, responses and
// configuration writes. Depends on bcm_pkg for field widths.
`default_nettype none

interface bcm_req_if;
   import bcm_pkg::*;
   logic             valid;
   logic             ready;
   logic             mode;
   logic [ROW_W-1:0] block_row;
   logic [COL_W-1:0] block_col;
   modport source (output valid, mode, block_row, block_col, input ready);
   modport sink   (input valid, mode, block_row, block_col, output ready);
endinterface

interface bcm_rsp_if;
   import bcm_pkg::*;
   logic                  valid;
   logic                  ready;
   status_type            status;
   logic [SLOT_OUT_W-1:0] slot;
   logic                  evicted_valid;
   logic [EVB_W-1:0]      evicted_block;
   modport source (output valid, status, slot, evicted_valid, evicted_block, input ready);
   modport sink   (input valid, status, slot, evicted_valid, evicted_block, output ready);
endinterface

interface bcm_csr_if;
   import bcm_pkg::*;
   logic              valid;
   logic              ready;
   csr_addr_type      addr;
   logic [GEOM_W-1:0] wdata;
   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

[design/bcm_ram.sv]
// bcm_ram: single write port, single read port synchronous memory with a
// registered read. No package dependency beyond parameter defaults.
`default_nettype none

module bcm_ram #(
   parameter int DEPTH = bcm_pkg::SLOTS_DEF,
   parameter int WIDTH = bcm_pkg::EVB_W
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/bcm_index.sv]
// bcm_index: two stage block index unit, row times blocks-across plus column,
// with grid and map range check. Depends on bcm_pkg.
`default_nettype none

module bcm_index #(
   parameter int MAX_BLOCKS = bcm_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          load,
   input  wire logic [bcm_pkg::ROW_W-1:0]     row,
   input  wire logic [bcm_pkg::COL_W-1:0]     col,
   input  wire logic [bcm_pkg::GEOM_W-1:0]    blocks_across,
   input  wire logic [bcm_pkg::GEOM_W-1:0]    blocks_down,
   output logic      [$clog2(MAX_BLOCKS)-1:0] idx,
   output logic                               bad
);

   import bcm_pkg::*;

   localparam int IW = $clog2(MAX_BLOCKS);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [COL_W-1:0]  col_ff;
   logic              coord_bad_ff;
   logic              coord_bad_in;
   logic [SUM_W-1:0]  sum;
   logic [IW-1:0]     idx_ff;
   logic              bad_ff;
   logic              bad_in;

   // stage one: product and coordinate check, taken with the request
   assign prod_in      = PROD_W'(row) * PROD_W'(blocks_across);
   assign coord_bad_in = (GEOM_W'(row) >= blocks_down) || (GEOM_W'(col) >= blocks_across);

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff      <= prod_in;
         col_ff       <= col;
         coord_bad_ff <= coord_bad_in;
      end
   end

   // stage two: add column and check against the map size
   assign sum    = SUM_W'(prod_ff) + SUM_W'(col_ff);
   assign bad_in = coord_bad_ff || (sum >= SUM_W'(MAX_BLOCKS));

   always_ff @(posedge clock) begin
      idx_ff <= sum[IW-1:0];
      bad_ff <= bad_in;
   end

   assign idx = idx_ff;
   assign bad = bad_ff;

endmodule

`default_nettype wire

[design/fifo_block_cache_map.sv]
// fifo_block_cache_map: top level of the block cache tag store, with control
// sequencer, geometry registers and response register. Depends on bcm_pkg,
// bcm_if, bcm_index and bcm_ram.
`default_nettype none

// Tag store for a cache of decoded image blocks with first-in-first-out
// replacement. Each request names a block by row and column; the block index
// (row * blocks_across + column) is looked up in a map memory of MAX_BLOCKS
// entries. A hit returns the slot; a miss takes the oldest slot, invalidates
// the block held there (reported as evicted once all slots have been used),
// records the new owner and advances the oldest pointer. A flush request
// clears the map and the pointer. Requests are handled one at a time; a
// finished response waits in an output register while the next request is
// taken. An out of range request ends after the index check; a hit ends
// when the map read returns; a miss then writes the map memory through its
// single write port, first clearing the evicted entry once all slots have
// been used, then the new entry; a flush sweeps the map one entry a cycle.
// After reset the same sweep of all MAX_BLOCKS entries (4096 by default)
// runs before the first request is taken; configuration writes are accepted
// throughout.
module fifo_block_cache_map #(
   parameter int SLOTS      = bcm_pkg::SLOTS_DEF,
   parameter int MAX_BLOCKS = bcm_pkg::MAX_BLOCKS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   bcm_req_if.sink   req_bus,
   bcm_rsp_if.source rsp_bus,
   bcm_csr_if.sink   csr_bus
);

   import bcm_pkg::*;

   localparam int SW = $clog2(SLOTS);
   localparam int IW = $clog2(MAX_BLOCKS);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ADD   = 3'd1;
   localparam logic [2:0] S_LOOK  = 3'd2;
   localparam logic [2:0] S_DATA  = 3'd3;
   localparam logic [2:0] S_FILL  = 3'd4;
   localparam logic [2:0] S_CLEAR = 3'd5;
   localparam logic [2:0] S_FDONE = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [IW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic              flush_pend_ff, flush_pend_in;
   logic [SW-1:0]     oldest_ff, oldest_in;
   logic              wrapped_ff, wrapped_in;
   logic [GEOM_W-1:0] across_ff, down_ff;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   logic                  rsp_evv_ff;
   logic [EVB_W-1:0]      rsp_evb_ff;

   logic          req_fire;
   logic          out_free;
   logic          emit;
   status_type    emit_status;
   logic [SW-1:0] emit_slot;
   logic          emit_evv;
   logic [IW-1:0] emit_evb;

   logic [IW-1:0] idx;
   logic          idx_bad;

   // map memory: valid bit over slot number
   logic          map_wr_en;
   logic [IW-1:0] map_wr_addr;
   logic [SW:0]   map_wr_data;
   logic          map_rd_en;
   logic [SW:0]   map_rd_data;
   logic          map_hit;

   // owner memory: block index held by each slot
   logic          own_wr_en;
   logic [IW-1:0] own_rd_data;

   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign map_rd_en     = (state_ff == S_LOOK);
   assign map_hit       = map_rd_data[SW];

   // block index unit, loaded as the request is taken
   bcm_index #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_index (
      .clock         (clock),
      .load          (req_fire),
      .row           (req_bus.block_row),
      .col           (req_bus.block_col),
      .blocks_across (across_ff),
      .blocks_down   (down_ff),
      .idx           (idx),
      .bad           (idx_bad)
   );

   bcm_ram #(
      .DEPTH (MAX_BLOCKS),
      .WIDTH (SW + 1)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (map_rd_en),
      .rd_addr (idx),
      .rd_data (map_rd_data)
   );

   bcm_ram #(
      .DEPTH (SLOTS),
      .WIDTH (IW)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (own_wr_en),
      .wr_addr (oldest_ff),
      .wr_data (idx),
      .rd_en   (map_rd_en),
      .rd_addr (oldest_ff),
      .rd_data (own_rd_data)
   );

   // sequencer: one request at a time, so no map access overlaps another
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      flush_pend_in = flush_pend_ff;
      oldest_in     = oldest_ff;
      wrapped_in    = wrapped_ff;
      emit          = 1'b0;
      emit_status   = ST_HIT;
      emit_slot     = '0;
      emit_evv      = 1'b0;
      emit_evb      = '0;
      map_wr_en     = 1'b0;
      map_wr_addr   = idx;
      map_wr_data   = '0;
      own_wr_en     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_bus.mode) begin
                  // flush: pointer restarts, map is swept
                  state_in      = S_CLEAR;
                  clr_cnt_in    = '0;
                  flush_pend_in = 1'b1;
                  oldest_in     = '0;
                  wrapped_in    = 1'b0;
               end else begin
                  state_in = S_ADD;
               end
            end
         end
         S_ADD: begin
            state_in = S_LOOK;
         end
         S_LOOK: begin
            // map and owner reads go out here
            if (idx_bad) begin
               if (out_free) begin
                  emit        = 1'b1;
                  emit_status = ST_RANGE;
                  state_in    = S_IDLE;
               end
            end else begin
               state_in = S_DATA;
            end
         end
         S_DATA: begin
            if (out_free) begin
               emit = 1'b1;
               if (map_hit) begin
                  emit_status = ST_HIT;
                  emit_slot   = map_rd_data[SW-1:0];
                  state_in    = S_IDLE;
               end else begin
                  emit_status = ST_MISS;
                  emit_slot   = oldest_ff;
                  emit_evv    = wrapped_ff;
                  emit_evb    = wrapped_ff ? own_rd_data : '0;
                  own_wr_en   = 1'b1;
                  // old owner loses its map entry before the new one goes in
                  if (wrapped_ff) begin
                     map_wr_en   = 1'b1;
                     map_wr_addr = own_rd_data;
                     map_wr_data = '0;
                  end
                  state_in = S_FILL;
               end
            end
         end
         S_FILL: begin
            map_wr_en   = 1'b1;
            map_wr_addr = idx;
            map_wr_data = {1'b1, oldest_ff};
            if (oldest_ff == SW'(SLOTS - 1)) begin
               oldest_in  = '0;
               wrapped_in = 1'b1;
            end else begin
               oldest_in = oldest_ff + SW'(1);
            end
            state_in = S_IDLE;
         end
         S_CLEAR: begin
            map_wr_en   = 1'b1;
            map_wr_addr = clr_cnt_ff;
            map_wr_data = '0;
            clr_cnt_in  = clr_cnt_ff + IW'(1);
            if (clr_cnt_ff == IW'(MAX_BLOCKS - 1)) begin
               state_in = flush_pend_ff ? S_FDONE : S_IDLE;
            end
         end
         S_FDONE: begin
            if (out_free) begin
               emit          = 1'b1;
               emit_status   = ST_FLUSH;
               flush_pend_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // reset starts with a sweep of the map and no flush response owed
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         flush_pend_ff <= 1'b0;
         oldest_ff     <= '0;
         wrapped_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         flush_pend_ff <= flush_pend_in;
         oldest_ff     <= oldest_in;
         wrapped_ff    <= wrapped_in;
      end
   end

   // geometry registers, always writable
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         across_ff <= GEOM_W'(1);
         down_ff   <= GEOM_W'(1);
      end else if (csr_bus.valid) begin
         unique case (csr_bus.addr)
            REG_BLOCKS_ACROSS: across_ff <= csr_bus.wdata;
            REG_BLOCKS_DOWN:   down_ff   <= csr_bus.wdata;
            default: begin
            end
         endcase
      end
   end

   // response register: loads when empty or being drained
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_slot_ff   <= SLOT_OUT_W'(emit_slot);
         rsp_evv_ff    <= emit_evv;
         rsp_evb_ff    <= EVB_W'(emit_evb);
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.slot          = rsp_slot_ff;
   assign rsp_bus.evicted_valid = rsp_evv_ff;
   assign rsp_bus.evicted_block = rsp_evb_ff;

`ifndef ASSERT_OFF
   // the wrapped flag only drops through a flush request
   a_wrap_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(wrapped_ff) |-> $past(req_fire && req_bus.mode))
      else $error("wrapped flag cleared without a flush request");

   // every fill moves the replacement pointer on
   a_fill_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |=> (oldest_ff != $past(oldest_ff)))
      else $error("oldest pointer did not advance on a fill");

   // the sweep leaves only after the last map entry
   a_sweep_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && state_in != S_CLEAR) |-> (clr_cnt_ff == IW'(MAX_BLOCKS - 1)))
      else $error("map sweep ended early");

   // responses come only from states that finish a request
   a_emit_state: assert property (@(posedge clock) disable iff (reset)
      emit |-> (state_ff == S_LOOK || state_ff == S_DATA || state_ff == S_FDONE))
      else $error("response loaded outside a finishing state");
`endif

endmodule

`default_nettype wire
